// ===== rtl/cst_pkg.sv =====
// Shared types and constants for the cursor sequence table.
`default_nettype none
package cst_pkg;
  localparam int Capacity = 32;
  localparam int AddrBits = 5;
  localparam int CountBits = 6;
  localparam int NameBits = 32;
  localparam int InfoBits = 32;
  localparam int EntryBits = NameBits + InfoBits;

  typedef enum logic [3:0] {
    ACT_START = 4'd0, ACT_ADVANCE = 4'd1, ACT_INSERT = 4'd2, ACT_ATTACH = 4'd3,
    ACT_REMCUR = 4'd4, ACT_REMONE = 4'd5, ACT_FIND = 4'd6, ACT_READIDX = 4'd7,
    ACT_INSFRONT = 4'd8, ACT_REMFRONT = 4'd9, ACT_ATTEND = 4'd10, ACT_REMEND = 4'd11
  } action_t;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_NOCUR = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;
  localparam logic [5:0] POS_NONE = 6'h3F;

  // controller -> datapath
  typedef struct packed {
    logic           load;      // capture input item
    logic           rd_en;
    logic [AddrBits-1:0] rd_addr;
    logic           wr_en;
    logic [AddrBits-1:0] wr_addr;
    logic           wr_new;    // write the new entry instead of read data
    logic           cmp_en;    // compare read data this cycle
    logic           out_load;  // capture read data as result item payload
    logic           out_zero;  // result item payload is zero
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic name_hit;
    logic full_hit;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/cst_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cst_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== rtl/cst_datapath.sv =====
// Entry storage, match compare and result payload register.
`default_nettype none
module cst_datapath (
  input  wire logic                       clk,
  input  wire cst_pkg::dp_cmd_t           cmd,
  input  wire logic [cst_pkg::NameBits-1:0] in_name,
  input  wire logic [cst_pkg::InfoBits-1:0] in_info,
  output cst_pkg::dp_stat_t               stat,
  output logic [cst_pkg::NameBits-1:0]    out_name,
  output logic [cst_pkg::InfoBits-1:0]    out_info
);
  logic [cst_pkg::NameBits-1:0]  key_name;
  logic [cst_pkg::InfoBits-1:0]  key_info;
  logic [cst_pkg::EntryBits-1:0] rd_data;
  logic [cst_pkg::EntryBits-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_name <= in_name;
      key_info <= in_info;
    end
    if (cmd.out_load) begin
      out_name <= cmd.out_zero ? '0 : rd_data[cst_pkg::EntryBits-1:cst_pkg::InfoBits];
      out_info <= cmd.out_zero ? '0 : rd_data[cst_pkg::InfoBits-1:0];
    end
  end

  assign wr_data = cmd.wr_new ? {key_name, key_info} : rd_data;

  cst_ram #(.Width(cst_pkg::EntryBits), .Depth(cst_pkg::Capacity)) u_store (
    .clk, .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr), .wr_data,
    .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data
  );

  always_comb begin
    stat.name_hit = cmd.cmp_en && (rd_data[cst_pkg::EntryBits-1:cst_pkg::InfoBits] == key_name);
    stat.full_hit = stat.name_hit && (rd_data[cst_pkg::InfoBits-1:0] == key_info);
  end
endmodule
`default_nettype wire

// ===== rtl/cst_ctrl.sv =====
// Sequencer: walks the store for shifts and searches, keeps count and cursor.
`default_nettype none
module cst_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [3:0]          in_action,
  input  wire logic [cst_pkg::AddrBits-1:0] in_rpos,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cst_pkg::dp_cmd_t         cmd,
  input  wire cst_pkg::dp_stat_t   stat,
  output logic [2:0]               status,
  output logic [cst_pkg::CountBits-1:0] count,
  output logic [cst_pkg::CountBits-1:0] cursor,
  output logic [5:0]               found
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_SHUP   = 7'b0000100,  // move entries up, top down
    S_SHDN   = 7'b0001000,  // move entries down, bottom up
    S_SEARCH = 7'b0010000,
    S_FETCH  = 7'b0100000,  // read result entry
    S_OUT    = 7'b1000000
  } state_t;

  localparam logic [cst_pkg::CountBits-1:0] CapCount = cst_pkg::CountBits'(cst_pkg::Capacity);
  localparam logic [cst_pkg::CountBits-1:0] One = cst_pkg::CountBits'(1);

  state_t state;
  logic [3:0] action;
  logic [cst_pkg::AddrBits-1:0] rpos;
  logic [cst_pkg::CountBits-1:0] pos;      // target position of insert
  logic [cst_pkg::CountBits-1:0] idx;      // next address to read (one above it during an up-shift)
  logic rd_pend;                           // read issued last cycle
  logic [cst_pkg::CountBits-1:0] rd_idx;   // index of pending read
  logic read_ok;

  logic on_entry;
  logic rd_hit;
  logic [cst_pkg::CountBits-1:0] ins_pos;
  logic [cst_pkg::CountBits-1:0] rem_pos;

  assign on_entry = cursor < count;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign rd_hit = rd_pend &&
                  ((action == cst_pkg::ACT_FIND && stat.name_hit) ||
                   (action == cst_pkg::ACT_REMONE && stat.full_hit));

  always_comb begin
    if (action == cst_pkg::ACT_INSFRONT ||
        (action == cst_pkg::ACT_INSERT && !on_entry)) ins_pos = '0;
    else if (action == cst_pkg::ACT_INSERT) ins_pos = cursor;
    else if (action == cst_pkg::ACT_ATTEND || !on_entry) ins_pos = count;
    else ins_pos = cursor + One;
    if (action == cst_pkg::ACT_REMFRONT) rem_pos = '0;
    else if (action == cst_pkg::ACT_REMEND) rem_pos = count - One;
    else rem_pos = cursor;
  end

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    cmd.rd_addr = idx[cst_pkg::AddrBits-1:0];
    cmd.wr_addr = rd_idx[cst_pkg::AddrBits-1:0];
    case (state)
      S_SHUP: begin
        // read idx-1, write it one place up next cycle; new entry goes last
        cmd.rd_en = (idx > pos);
        cmd.rd_addr = cst_pkg::AddrBits'(idx - One);
        cmd.wr_en = rd_pend || (idx == pos);
        cmd.wr_new = !rd_pend;
        cmd.wr_addr = rd_pend ? cst_pkg::AddrBits'(rd_idx + One) : pos[cst_pkg::AddrBits-1:0];
      end
      S_SHDN: begin
        cmd.rd_en = (idx < count);
        cmd.wr_en = rd_pend;
        cmd.wr_addr = cst_pkg::AddrBits'(rd_idx - One);
      end
      S_SEARCH: begin
        cmd.rd_en = (idx < count);
        cmd.cmp_en = rd_pend;
      end
      S_FETCH: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = read_ok ? rpos : cursor[cst_pkg::AddrBits-1:0];
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        cmd.out_zero = !read_ok && !on_entry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      count <= '0;
      cursor <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            action <= in_action;
            rpos <= in_rpos;
            status <= cst_pkg::ST_OK;
            found <= cst_pkg::POS_NONE;
            read_ok <= 1'b0;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_FETCH;
          rd_pend <= 1'b0;
          case (action)
            cst_pkg::ACT_START: cursor <= '0;
            cst_pkg::ACT_ADVANCE:
              if (on_entry) cursor <= cursor + One;
              else status <= cst_pkg::ST_NOCUR;
            cst_pkg::ACT_INSERT, cst_pkg::ACT_INSFRONT,
            cst_pkg::ACT_ATTACH, cst_pkg::ACT_ATTEND: begin
              if (count >= CapCount) status <= cst_pkg::ST_FULL;
              else begin
                cursor <= ins_pos;
                pos <= ins_pos;
                idx <= count;
                state <= S_SHUP;
              end
            end
            cst_pkg::ACT_REMCUR, cst_pkg::ACT_REMFRONT, cst_pkg::ACT_REMEND: begin
              if ((action == cst_pkg::ACT_REMCUR && !on_entry) || count == '0)
                status <= cst_pkg::ST_NOCUR;
              else begin
                cursor <= rem_pos;
                idx <= rem_pos + One;
                state <= S_SHDN;
              end
            end
            cst_pkg::ACT_REMONE, cst_pkg::ACT_FIND: begin
              status <= cst_pkg::ST_NOTFOUND;
              idx <= '0;
              state <= S_SEARCH;
            end
            cst_pkg::ACT_READIDX:
              if ({1'b0, rpos} < count) read_ok <= 1'b1;
              else status <= cst_pkg::ST_RANGE;
            default: ;
          endcase
        end
        S_SHUP: begin
          if (idx > pos) begin
            rd_pend <= 1'b1;
            rd_idx <= idx - One;
            idx <= idx - One;
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
          end else begin
            count <= count + One;
            state <= S_FETCH;
          end
        end
        S_SHDN: begin
          // read idx, write the previous read one place down
          if (idx < count) begin
            rd_pend <= 1'b1;
            rd_idx <= idx;
            idx <= idx + One;
          end else begin
            rd_pend <= 1'b0;
            count <= count - One;
            state <= S_FETCH;
          end
        end
        S_SEARCH: begin
          if (idx < count) begin
            rd_pend <= 1'b1;
            rd_idx <= idx;
            idx <= idx + One;
          end else rd_pend <= 1'b0;
          if (rd_hit) begin
            cursor <= rd_idx;
            status <= cst_pkg::ST_OK;
            rd_pend <= 1'b0;
            if (action == cst_pkg::ACT_FIND) begin
              found <= rd_idx;
              state <= S_FETCH;
            end else begin
              idx <= rd_idx + One;
              state <= S_SHDN;
            end
          end else if (idx >= count) state <= S_FETCH;
        end
        S_FETCH: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/cursor_sequence_table.sv =====
// Top level of the cursor sequence table.
// Each action passes through the decide, fetch and output states; accepted insert and remove
// actions first walk the store to shift entries up or down, and find and remove-one actions
// first search it, comparing each entry against the input item.
// One item at a time: a new input item is taken only once the result item has been accepted.
// Reset (rst, synchronous): empty table, cursor 0; store content is left.
`default_nettype none
module cursor_sequence_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // entry_name, entry_info, read_position, zero pad
  input  wire logic [3:0]  s_tuser,  // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata   // status, count, cursor, has_current,
                                     // item_name, item_info, found_position, zero pad
);
  cst_pkg::dp_cmd_t  cmd;
  cst_pkg::dp_stat_t stat;
  logic [2:0] status;
  logic [5:0] count, cursor, found;
  logic [31:0] out_name, out_info;

  cst_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_action(s_tuser),
    .in_rpos(s_tdata[68:64]), .out_valid(m_tvalid), .out_ready(m_tready),
    .cmd, .stat, .status, .count, .cursor, .found
  );

  cst_datapath u_dp (
    .clk, .cmd, .in_name(s_tdata[31:0]), .in_info(s_tdata[63:32]),
    .stat, .out_name, .out_info
  );

  assign m_tdata = {2'd0, found, out_info, out_name, (cursor < count), cursor, count, status};

  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= 6'd32)
    else $error("count above capacity");
  a_cursor_cap: assert property (@(posedge clk) disable iff (rst)
    cursor <= count || m_tvalid == 1'b0 || cursor <= 6'd32)
    else $error("cursor out of range");
  a_one_busy: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input taken while result pending");
endmodule
`default_nettype wire
